// ===== rtl/ctab_pkg.sv =====
`default_nettype none
package ctab_pkg;

    localparam int SAMPLE_W      = 32;
    localparam int VAR_W         = 64;
    localparam int HL_W          = 6;
    localparam int BW_W          = 12;
    localparam int CFG_DATA_W    = 12;
    localparam int SEEN_W        = 16;
    localparam int MAX_HALF_LEN  = 63;

    localparam logic [HL_W-1:0] HL_RESET = 6'd56;
    localparam logic [BW_W-1:0] BW_RESET = 12'd640;

    // configuration register indexes
    localparam logic CFG_HALF_LENGTH = 1'b0;
    localparam logic CFG_BAND_WIDTH  = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/centered_triangular_average_bands.sv =====
`default_nettype none
// Centered triangular moving average with asymmetric deviation bands. Price items
// (unsigned Q16.16) arrive oldest first; for each center sample the block returns the
// triangular weighted average over half length H (center weight H+1, neighbor at
// distance j weighs H+1-j), and an upper and lower band built from two one-sided
// exponential variances of length 2H+1. An item without i_last yields the center H
// samples back once 2H+1 samples are held; an item with i_last flushes every pending
// center oldest first, newer side truncated, and marks the newest with
// o_final_result. One item is handled at a time and o_stall is high while it is
// worked on. Each center takes H+1 older-side window reads plus up to H newer-side
// reads, three passes of one shared radix-2 divider (the average and both variance
// updates) and two 32-step square roots; the first center of a series takes only
// the average pass and seeds the variances. A flushing item does this for every
// center it emits. The result register holds until taken; the window is a circular
// memory of 2*MAX_HALF_LENGTH+1 entries.
module centered_triangular_average_bands #(
    parameter int MAX_HALF_LENGTH = ctab_pkg::MAX_HALF_LEN
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic                             i_cfg_index,
    input  wire logic [ctab_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input items
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [ctab_pkg::SAMPLE_W-1:0]    i_price,
    input  wire logic                             i_last,
    // result items
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [ctab_pkg::SAMPLE_W-1:0]         o_centre_average,
    output logic [ctab_pkg::SAMPLE_W-1:0]         o_upper_band,
    output logic [ctab_pkg::SAMPLE_W-1:0]         o_lower_band,
    output logic                                  o_final_result
);

    localparam int SW_   = ctab_pkg::SAMPLE_W;
    localparam int VW    = ctab_pkg::VAR_W;
    localparam int DEPTH = 2 * MAX_HALF_LENGTH + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_HALF_LENGTH + 2);   // holds H+1
    localparam int WSW   = 2 * WW;                         // weight sum
    localparam int SMW   = SW_ + WSW;                      // weighted sum
    localparam int NW    = VW + WSW;                       // divider numerator
    localparam int CW    = $clog2(NW + 1);
    localparam int SEW   = ctab_pkg::SEEN_W;

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_SCAN    = 13'b0000000000010,
        ST_RD_OLD  = 13'b0000000000100,
        ST_MAC_OLD = 13'b0000000001000,
        ST_RD_NEW  = 13'b0000000010000,
        ST_MAC_NEW = 13'b0000000100000,
        ST_DIV     = 13'b0000001000000,
        ST_SQ      = 13'b0000010000000,
        ST_DEC_UP  = 13'b0000100000000,
        ST_DEC_DN  = 13'b0001000000000,
        ST_SQRT    = 13'b0010000000000,
        ST_DEV     = 13'b0100000000000,
        ST_OUT     = 13'b1000000000000
    } t_state;

    typedef enum logic [1:0] {
        PH_AVG = 2'd0,
        PH_UP  = 2'd1,
        PH_DN  = 2'd2
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    logic [ctab_pkg::HL_W-1:0] r_hl;
    logic [ctab_pkg::BW_W-1:0] r_bw;

    logic [SW_-1:0] r_win [DEPTH];
    logic [SW_-1:0] r_rdata;
    logic [AW-1:0]  r_wp;          // newest sample
    logic [SEW-1:0] r_seen;
    logic [VW-1:0]  r_vup, r_vdn;
    logic           r_started;

    logic [WW-1:0]  r_h, r_d, r_j;
    logic           r_flush, r_fin, r_pos;
    logic [SMW-1:0] r_sum;
    logic [WSW-1:0] r_sumw;
    logic [SW_-1:0] r_ctr, r_avg, r_up, r_dn;
    logic [VW-1:0]  r_d2;

    logic [NW-1:0]  r_num;
    logic [WSW-1:0] r_den;
    logic [WSW-1:0] r_rem;
    logic [CW-1:0]  r_cnt;
    logic [VW-1:0]  r_srem, r_sroot, r_sbit;

    // ---------------- combinational helpers ----------------
    logic           acc;
    logic [AW-1:0]  wp_next;
    logic [SEW-1:0] seen_inc;
    logic [WW-1:0]  h_eff;
    logic [WW-1:0]  w;
    logic [AW:0]    k, a_full;
    logic [AW-1:0]  raddr;
    logic [WW+SW_-1:0] mac_prod;
    logic [SMW-1:0] sum_nx;
    logic [WSW-1:0] sumw_nx;
    logic           new_side;
    logic [WSW:0]   rem_sh;
    logic           dv_ge;
    logic [WSW-1:0] rem_nx;
    logic [NW-1:0]  quo_nx;
    logic [VW-1:0]  s_t;
    logic           s_ge;
    logic           pos;
    logic [SW_-1:0] mag;
    logic [VW-1:0]  d2;
    logic [VW-1:0]  dec_v, dec_add;
    logic [VW+WW:0] dec_prod;
    logic [43:0]    dev_prod;
    logic [35:0]    dev;
    logic [SW_:0]   up_sum;
    logic [SW_-1:0] up_sat, dn_val;

    assign acc      = i_valid && (r_state == ST_IDLE);
    assign wp_next  = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign seen_inc = (r_seen == '1) ? r_seen : r_seen + 1'b1;

    always_comb begin
        if (r_hl == '0) begin
            h_eff = WW'(1);
        end else if (int'(r_hl) > MAX_HALF_LENGTH) begin
            h_eff = WW'(MAX_HALF_LENGTH);
        end else begin
            h_eff = WW'(r_hl);
        end
    end

    // window address of the sample k places older than the newest
    assign w      = (r_h - r_j) + 1'b1;
    assign k      = (r_state == ST_RD_NEW) ? ((AW+1)'(r_d) - (AW+1)'(r_j))
                                           : ((AW+1)'(r_d) + (AW+1)'(r_j));
    assign a_full = (AW+1)'(r_wp) + (AW+1)'(DEPTH) - k;
    assign raddr  = (a_full >= (AW+1)'(DEPTH)) ? AW'(a_full - (AW+1)'(DEPTH))
                                               : AW'(a_full);

    assign mac_prod = {{SW_{1'b0}}, w} * {{WW{1'b0}}, r_rdata};
    assign sum_nx   = r_sum + SMW'(mac_prod);
    assign sumw_nx  = r_sumw + WSW'(w);
    assign new_side = (r_j != '0) && (r_j <= r_d);

    // restoring divider, one quotient bit per cycle
    assign rem_sh = {r_rem, r_num[NW-1]};
    assign dv_ge  = rem_sh >= {1'b0, r_den};
    assign rem_nx = dv_ge ? WSW'(rem_sh - {1'b0, r_den}) : WSW'(rem_sh);
    assign quo_nx = {r_num[NW-2:0], dv_ge};

    // square root, one result bit per cycle
    assign s_t  = r_sroot + r_sbit;
    assign s_ge = r_srem >= s_t;

    assign pos = r_ctr >= r_avg;
    assign mag = pos ? (r_ctr - r_avg) : (r_avg - r_ctr);
    assign d2  = {{SW_{1'b0}}, mag} * {{SW_{1'b0}}, mag};

    // decay numerator: v*(L-1) + add, L = 2H+1
    assign dec_v    = (r_state == ST_DEC_UP) ? r_vup : r_vdn;
    assign dec_add  = ((r_state == ST_DEC_UP) == r_pos) ? r_d2 : '0;
    assign dec_prod = {{(WW+1){1'b0}}, dec_v} * {{VW{1'b0}}, r_h, 1'b0};

    assign dev_prod = {32'd0, r_bw} * {12'd0, r_sroot[SW_-1:0]};
    assign dev      = 36'((dev_prod + 44'd128) >> 8);
    assign up_sum   = (SW_+1)'(r_avg) + (SW_+1)'(dev);
    assign up_sat   = (up_sum[SW_] || (dev[35:SW_] != '0)) ? '1 : up_sum[SW_-1:0];
    assign dn_val   = (dev >= 36'(r_avg)) ? '0 : r_avg - dev[SW_-1:0];

    // ---------------- window memory ----------------
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_win[wp_next] <= i_price;
        end
        r_rdata <= r_win[raddr];
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hl <= ctab_pkg::HL_RESET;
            r_bw <= ctab_pkg::BW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ctab_pkg::CFG_HALF_LENGTH: r_hl <= i_cfg_data[ctab_pkg::HL_W-1:0];
                ctab_pkg::CFG_BAND_WIDTH:  r_bw <= i_cfg_data[ctab_pkg::BW_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer and datapath ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_AVG;
            r_wp      <= '0;
            r_seen    <= '0;
            r_vup     <= '0;
            r_vdn     <= '0;
            r_started <= 1'b0;
            r_flush   <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        r_wp   <= wp_next;
                        r_seen <= seen_inc;
                        r_h    <= h_eff;
                        r_d    <= h_eff;
                        r_j    <= '0;
                        r_sum  <= '0;
                        r_sumw <= '0;
                        r_fin  <= 1'b0;
                        r_flush <= i_last;
                        if (i_last) begin
                            r_state <= ST_SCAN;
                        end else if (seen_inc >= SEW'({h_eff, 1'b1})) begin
                            r_state <= ST_RD_OLD;
                        end
                    end
                end
                ST_SCAN: begin
                    r_j    <= '0;
                    r_sum  <= '0;
                    r_sumw <= '0;
                    if (r_seen >= SEW'(r_d) + SEW'(r_h) + 1'b1) begin
                        r_fin   <= (r_d == '0);
                        r_state <= ST_RD_OLD;
                    end else if (r_d == '0) begin
                        r_seen    <= '0;
                        r_started <= 1'b0;
                        r_state   <= ST_IDLE;
                    end else begin
                        r_d <= r_d - 1'b1;
                    end
                end
                ST_RD_OLD: r_state <= ST_MAC_OLD;
                ST_RD_NEW: r_state <= ST_MAC_NEW;
                ST_MAC_OLD, ST_MAC_NEW: begin
                    r_sum  <= sum_nx;
                    r_sumw <= sumw_nx;
                    if (r_state == ST_MAC_OLD && r_j == '0) begin
                        r_ctr <= r_rdata;
                    end
                    if (r_state == ST_MAC_OLD && new_side) begin
                        r_state <= ST_RD_NEW;
                    end else if (r_j == r_h) begin
                        // rounded average: (sum + sumw/2) / sumw
                        r_num   <= NW'(sum_nx) + NW'(sumw_nx >> 1);
                        r_den   <= sumw_nx;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_phase <= PH_AVG;
                        r_state <= ST_DIV;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= ST_RD_OLD;
                    end
                end
                ST_DIV: begin
                    r_rem <= rem_nx;
                    r_num <= quo_nx;
                    if (r_cnt == CW'(NW - 1)) begin
                        case (r_phase)
                            PH_AVG: begin
                                r_avg   <= quo_nx[SW_-1:0];
                                r_state <= ST_SQ;
                            end
                            PH_UP: begin
                                r_vup   <= quo_nx[VW-1:0];
                                r_state <= ST_DEC_DN;
                            end
                            PH_DN: begin
                                r_vdn   <= quo_nx[VW-1:0];
                                r_srem  <= r_vup;
                                r_sroot <= '0;
                                r_sbit  <= {2'b01, {(VW-2){1'b0}}};
                                r_cnt   <= '0;
                                r_phase <= PH_UP;
                                r_state <= ST_SQRT;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SQ: begin
                    r_pos <= pos;
                    r_d2  <= d2;
                    if (!r_started) begin
                        // first center of a series seeds the variances
                        r_started <= 1'b1;
                        r_vup     <= pos ? d2 : '0;
                        r_vdn     <= pos ? '0 : d2;
                        r_up      <= r_avg;
                        r_dn      <= r_avg;
                        r_state   <= ST_OUT;
                    end else begin
                        r_state <= ST_DEC_UP;
                    end
                end
                ST_DEC_UP, ST_DEC_DN: begin
                    r_num   <= NW'(dec_prod) + NW'(dec_add);
                    r_den   <= WSW'({r_h, 1'b1});
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_phase <= (r_state == ST_DEC_UP) ? PH_UP : PH_DN;
                    r_state <= ST_DIV;
                end
                ST_SQRT: begin
                    r_srem  <= s_ge ? r_srem - s_t : r_srem;
                    r_sroot <= s_ge ? (r_sroot >> 1) + r_sbit : r_sroot >> 1;
                    r_sbit  <= r_sbit >> 2;
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == CW'(SW_ - 1)) begin
                        r_state <= ST_DEV;
                    end
                end
                ST_DEV: begin
                    if (r_phase == PH_UP) begin
                        r_up    <= up_sat;
                        r_srem  <= r_vdn;
                        r_sroot <= '0;
                        r_sbit  <= {2'b01, {(VW-2){1'b0}}};
                        r_cnt   <= '0;
                        r_phase <= PH_DN;
                        r_state <= ST_SQRT;
                    end else begin
                        r_dn    <= dn_val;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!i_stall) begin
                        if (!r_flush) begin
                            r_state <= ST_IDLE;
                        end else if (r_d == '0) begin
                            r_seen    <= '0;
                            r_started <= 1'b0;
                            r_state   <= ST_IDLE;
                        end else begin
                            r_d     <= r_d - 1'b1;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall          = (r_state != ST_IDLE);
    assign o_valid          = (r_state == ST_OUT);
    assign o_centre_average = r_avg;
    assign o_upper_band     = r_up;
    assign o_lower_band     = r_dn;
    assign o_final_result   = r_fin;

endmodule
`default_nettype wire

// ===== tb/sv/centered_triangular_average_bands_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module centered_triangular_average_bands_test;

    localparam int SW          = ctab_pkg::SAMPLE_W;
    localparam int HLW         = ctab_pkg::HL_W;
    localparam int BWW         = ctab_pkg::BW_W;
    localparam int CDW         = ctab_pkg::CFG_DATA_W;
    localparam int WIN_DEPTH   = 2 * ctab_pkg::MAX_HALF_LEN + 1;
    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS       = 130;

    typedef struct packed {
        logic [SW-1:0] price;
        logic          last;
    } t_sample;

    typedef struct packed {
        logic [SW-1:0] avg;
        logic [SW-1:0] upper;
        logic [SW-1:0] lower;
        logic          fin;
    } t_band;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_we;
    logic           i_cfg_index;
    logic [CDW-1:0] i_cfg_data;
    logic           i_valid;
    logic           o_stall;
    logic [SW-1:0]  i_price;
    logic           i_last;
    logic           o_valid;
    logic           i_stall;
    logic [SW-1:0]  o_centre_average;
    logic [SW-1:0]  o_upper_band;
    logic [SW-1:0]  o_lower_band;
    logic           o_final_result;

    centered_triangular_average_bands dut (.*);

    // predictor state
    logic [HLW-1:0] p_half;
    logic [BWW-1:0] p_bw;
    logic [SW-1:0]  p_win [WIN_DEPTH];
    int unsigned    p_seen;
    logic [63:0]    p_var_up;
    logic [63:0]    p_var_dn;
    bit             p_started;

    t_sample pending_samples[$];
    t_band   expected_bands[$];
    int      errors = 0;
    int      idle_cycles = 0;
    int      sent = 0;
    bit      send_idle_ok = 1;   // random idling on the sender
    bit      recv_idle_ok = 1;
    bit      hold_req = 0;       // ask the receiver for one long hold-off
    bit      hold_done = 0;
    int      hold_left = 0;
    bit      sent_pulse;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] rem, root, b;
        rem = v; root = 0; b = 64'h1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // floor((v*(len-1)+add)/len) in 128 bits, no overflow concern
    function automatic logic [63:0] decay_var(logic [63:0] v, logic [63:0] add,
                                              logic [63:0] len);
        logic [127:0] t;
        t = ({64'd0, v} * (len - 1)) + add;
        return 64'(t / len);
    endfunction

    function automatic logic [63:0] band_dev(logic [63:0] var_q);
        logic [127:0] t;
        t = {116'd0, p_bw} * isqrt(var_q) + 128;
        return 64'(t >> 8);
    endfunction

    // one center at distance d from newest
    function automatic t_band center_band(int unsigned d, int unsigned h, bit fin);
        logic [95:0] sum, sumw, w;
        logic [63:0] avg, mag, d2, up, dn, len, c;
        bit          pos;
        t_band       r;
        c = p_win[d];
        sum = (h + 1) * c;
        sumw = h + 1;
        len = 2 * h + 1;
        for (int unsigned j = 1; j <= h; j++) begin
            w = h + 1 - j;
            sum += w * p_win[d + j];
            sumw += w;
            if (j <= d) begin
                sum += w * p_win[d - j];
                sumw += w;
            end
        end
        avg = 64'((sum + sumw / 2) / sumw);
        pos = c >= avg;
        mag = pos ? c - avg : avg - c;
        d2 = mag > 64'hFFFF_FFFF ? '1 : mag * mag;
        if (!p_started) begin
            p_started = 1;
            p_var_up = pos ? d2 : 0;
            p_var_dn = pos ? 0 : d2;
            up = avg;
            dn = avg;
        end else begin
            p_var_up = decay_var(p_var_up, pos ? d2 : 64'd0, len);
            p_var_dn = decay_var(p_var_dn, pos ? 64'd0 : d2, len);
            up = avg + band_dev(p_var_up);
            if (up > 64'hFFFF_FFFF) up = 64'hFFFF_FFFF;
            dn = band_dev(p_var_dn);
            dn = dn >= avg ? 64'd0 : avg - dn;
        end
        r.avg = avg[31:0];
        r.upper = up[31:0];
        r.lower = dn[31:0];
        r.fin = fin;
        return r;
    endfunction

    task automatic predict_sample(t_sample s);
        int unsigned h;
        h = p_half == 0 ? 1 : p_half;
        for (int i = WIN_DEPTH - 1; i > 0; i--) p_win[i] = p_win[i - 1];
        p_win[0] = s.price;
        if (p_seen < 65535) p_seen++;
        if (!s.last) begin
            if (p_seen >= 2 * h + 1) expected_bands.push_back(center_band(h, h, 0));
        end else begin
            for (int d = h; d >= 0; d--)
                if (p_seen >= d + h + 1)
                    expected_bands.push_back(center_band(d, h, d == 0));
            p_seen = 0;
            p_started = 0;
        end
    endtask

    // driver: offers the head of the pending queue; items leave it once accepted
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_price <= '0;
            i_last  <= 1'b0;
        end else if (i_valid && !sent_pulse) begin
            // still offered, payload held
        end else if (pending_samples.size() > 0 &&
                     !(send_idle_ok && $urandom_range(99) < 10)) begin
            i_valid <= 1'b1;
            i_price <= pending_samples[0].price;
            i_last  <= pending_samples[0].last;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver: random stalls, and one long hold-off once a result is waiting
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done && o_valid) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end else begin
            i_stall <= recv_idle_ok && ($urandom_range(99) < 10);
        end
    end

    // monitor: accepted input items feed the predictor, results are checked
    always @(posedge i_clk) begin
        sent_pulse <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_sample(pending_samples.pop_front());
            end
            if (o_valid && !i_stall) begin
                if (expected_bands.size() == 0) begin
                    $display("%0t: result expected none actual avg %h",
                             $time, o_centre_average);
                    errors++;
                end else begin
                    t_band e;
                    e = expected_bands.pop_front();
                    if (o_centre_average !== e.avg) begin
                        $display("%0t: average expected %h actual %h",
                                 $time, e.avg, o_centre_average);
                        errors++;
                    end
                    if (o_upper_band !== e.upper) begin
                        $display("%0t: upper band expected %h actual %h",
                                 $time, e.upper, o_upper_band);
                        errors++;
                    end
                    if (o_lower_band !== e.lower) begin
                        $display("%0t: lower band expected %h actual %h",
                                 $time, e.lower, o_lower_band);
                        errors++;
                    end
                    if (o_final_result !== e.fin) begin
                        $display("%0t: final flag expected %b actual %b",
                                 $time, e.fin, o_final_result);
                        errors++;
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic queue_sample(logic [31:0] p, bit l);
        t_sample s;
        s.price = p;
        s.last = l;
        pending_samples.push_back(s);
        sent++;
    endtask

    task automatic wait_drained();
        while (pending_samples.size() > 0 || i_valid || expected_bands.size() > 0)
            @(posedge i_clk);
        // block may still be working on an item without results
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CDW-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        if (idx == ctab_pkg::CFG_HALF_LENGTH) p_half = val[HLW-1:0];
        else p_bw = val[BWW-1:0];
    endtask

    function automatic logic [31:0] rand_price(logic [31:0] base);
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'hFFFF_FFFF - $urandom_range(3);
            2: return $urandom_range(3);
            default: return base + $urandom_range(32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    // one series of n samples, last on the final one
    task automatic queue_series(int n);
        logic [31:0] base;
        base = $urandom;
        for (int i = 0; i < n; i++) queue_sample(rand_price(base), i == n - 1);
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = ctab_pkg::CFG_HALF_LENGTH;
        i_cfg_data = 0;
        p_half = ctab_pkg::HL_RESET;
        p_bw = ctab_pkg::BW_RESET;
        p_seen = 0;
        p_var_up = 0;
        p_var_dn = 0;
        p_started = 0;
        for (int i = 0; i < WIN_DEPTH; i++) p_win[i] = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        hold_req = 1;                          // first waiting result is held off

        // directed: short series with extremes, zero half length, tiny series
        write_reg(ctab_pkg::CFG_HALF_LENGTH, CDW'(0));
        write_reg(ctab_pkg::CFG_BAND_WIDTH, 12'hFFF);
        queue_sample(32'hFFFF_FFFF, 0);
        queue_sample(32'h0, 0);
        queue_sample(32'hFFFF_FFFF, 0);
        queue_sample(32'h5555_AAAA, 0);
        queue_sample(32'hAAAA_5555, 1);
        queue_sample(32'h1234_5678, 1);        // too short: nothing
        queue_sample(32'h0, 0);
        queue_sample(32'h0, 0);
        queue_sample(32'hFFFF_FFFF, 1);
        wait_drained();
        write_reg(ctab_pkg::CFG_HALF_LENGTH, CDW'(2));
        write_reg(ctab_pkg::CFG_BAND_WIDTH, CDW'(0));
        queue_series(8);
        queue_series(2);                       // H samples or fewer
        queue_sample(32'h8000_0000, 0);
        queue_sample(32'h7FFF_FFFF, 0);
        queue_sample(32'h8000_0000, 0);
        wait_drained();
        // mid-series change of half length
        write_reg(ctab_pkg::CFG_HALF_LENGTH, CDW'(1));
        queue_sample(32'h0001_0000, 0);
        queue_sample(32'h0002_0000, 1);
        wait_drained();

        // long series at the largest half length, no idling on either side
        send_idle_ok = 0;
        recv_idle_ok = 0;
        write_reg(ctab_pkg::CFG_HALF_LENGTH, CDW'(63));
        write_reg(ctab_pkg::CFG_BAND_WIDTH, CDW'($urandom_range(4095)));
        queue_series(80);
        wait_drained();
        send_idle_ok = 1;
        recv_idle_ok = 1;

        // random: short half lengths
        while (sent < ITEMS) begin
            int n;
            write_reg(ctab_pkg::CFG_HALF_LENGTH, CDW'($urandom_range(1, 5)));
            write_reg(ctab_pkg::CFG_BAND_WIDTH,
                      $urandom_range(3) == 0 ? ($urandom_range(1) ? 12'hFFF : 12'h0)
                                             : CDW'($urandom_range(4095)));
            n = $urandom_range(3, 20);
            if ($urandom_range(4) != 0) queue_series(n);
            else for (int i = 0; i < n; i++) queue_sample($urandom, $urandom_range(7) == 0);
            wait_drained();                    // sender pauses until all results are in
        end

        // settle on reset values
        write_reg(ctab_pkg::CFG_HALF_LENGTH, CDW'(ctab_pkg::HL_RESET));
        write_reg(ctab_pkg::CFG_BAND_WIDTH, CDW'(ctab_pkg::BW_RESET));
        wait_drained();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/ctab_pkg.sv
rtl/centered_triangular_average_bands.sv
tb/sv/centered_triangular_average_bands_test.sv
